// ===== rtl/ttb_pkg.sv =====
// Shared widths, types and state encodings of the triangle tangent basis block.
package ttb_pkg;

    localparam int PosW   = 32;           // vertex position, Q16.16
    localparam int TexW   = 24;           // texture coordinate, Q8.16
    localparam int EdgeW  = PosW + 1;     // position edge
    localparam int TedgeW = TexW + 1;     // texture edge
    localparam int ProdW  = EdgeW + TedgeW;
    localparam int WideW  = 60;           // determinant and unscaled vector sums
    localparam int UnitW  = 16;           // Q1.14 result
    localparam int MagW   = 24;           // normalized magnitude
    localparam int SqW    = 2 * MagW;
    localparam int SumW   = 50;           // sum of three squares
    localparam int RootW  = 25;           // square root of the sum
    localparam int NumW   = 40;           // division numerator
    localparam int QW     = 15;           // quotient bits
    localparam int NumRes = 7;            // determinant, tangent, binormal

    localparam logic [3:0] GeoLast   = 4'd13;
    localparam logic [3:0] CrossLast = 4'd5;
    localparam logic [3:0] QLast     = 4'(QW - 1);
    localparam logic [SumW-1:0] SqrtBit0 = SumW'(1) << (SumW - 2);

    typedef logic signed [PosW-1:0]   t_pos;
    typedef logic signed [TexW-1:0]   t_tex;
    typedef logic signed [EdgeW-1:0]  t_edge;
    typedef logic signed [TedgeW-1:0] t_tedge;
    typedef logic signed [ProdW-1:0]  t_prod;
    typedef logic signed [WideW-1:0]  t_wide;
    typedef logic signed [UnitW-1:0]  t_unit;

    typedef struct packed {
        t_edge  e1x;
        t_edge  e1y;
        t_edge  e1z;
        t_edge  e2x;
        t_edge  e2y;
        t_edge  e2z;
        t_tedge s1;
        t_tedge s2;
        t_tedge t1;
        t_tedge t2;
    } t_tri;

    typedef struct packed {
        logic  start;
        logic  neg;
        t_wide cx;
        t_wide cy;
        t_wide cz;
    } t_norm_req;

    typedef struct packed {
        logic  done;
        logic  zero;
        t_unit qx;
        t_unit qy;
        t_unit qz;
    } t_norm_rsp;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIV
    } t_nstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_ACC,
        B_CHK,
        B_NT,
        B_NB,
        B_NN,
        B_OUT
    } t_bstate;

endpackage

// ===== rtl/ttb_if.sv =====
// Vertex and basis stream interfaces with valid/ready handshake.
interface ttb_vtx_if import ttb_pkg::*; ();
    logic valid;
    logic ready;
    logic mesh_start;
    t_pos pos_x;
    t_pos pos_y;
    t_pos pos_z;
    t_tex tex_u;
    t_tex tex_v;

    modport source(output valid, mesh_start, pos_x, pos_y, pos_z, tex_u, tex_v,
                   input ready);
    modport sink(input valid, mesh_start, pos_x, pos_y, pos_z, tex_u, tex_v,
                 output ready);
endinterface

interface ttb_bas_if import ttb_pkg::*; ();
    logic  valid;
    logic  ready;
    t_unit tangent_x;
    t_unit tangent_y;
    t_unit tangent_z;
    t_unit binormal_x;
    t_unit binormal_y;
    t_unit binormal_z;
    t_unit normal_x;
    t_unit normal_y;
    t_unit normal_z;
    logic  degenerate;

    modport source(output valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                   binormal_z, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink(input valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                 binormal_z, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== rtl/ttb_front.sv =====
// Vertex grouping: holds two vertices and forms the edges of each triangle.
module ttb_front import ttb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttb_vtx_if.sink     i_vtx,
    input  logic        i_full,
    output logic        o_push,
    output t_tri        o_tri
);

    logic [1:0] r_cnt;
    logic [1:0] cnt_eff;
    logic       accept;
    t_pos       r_hpx [2];
    t_pos       r_hpy [2];
    t_pos       r_hpz [2];
    t_tex       r_htu [2];
    t_tex       r_htv [2];

    assign i_vtx.ready = !i_full;
    assign accept      = i_vtx.valid && !i_full;
    assign cnt_eff     = i_vtx.mesh_start ? 2'd0 : r_cnt;
    assign o_push      = accept && (cnt_eff == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= (cnt_eff == 2'd2) ? 2'd0 : cnt_eff + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (cnt_eff != 2'd2)) begin
            r_hpx[cnt_eff[0]] <= i_vtx.pos_x;
            r_hpy[cnt_eff[0]] <= i_vtx.pos_y;
            r_hpz[cnt_eff[0]] <= i_vtx.pos_z;
            r_htu[cnt_eff[0]] <= i_vtx.tex_u;
            r_htv[cnt_eff[0]] <= i_vtx.tex_v;
        end
    end

    always_comb begin
        o_tri.e1x = EdgeW'(r_hpx[1]) - EdgeW'(r_hpx[0]);
        o_tri.e1y = EdgeW'(r_hpy[1]) - EdgeW'(r_hpy[0]);
        o_tri.e1z = EdgeW'(r_hpz[1]) - EdgeW'(r_hpz[0]);
        o_tri.e2x = EdgeW'(i_vtx.pos_x) - EdgeW'(r_hpx[0]);
        o_tri.e2y = EdgeW'(i_vtx.pos_y) - EdgeW'(r_hpy[0]);
        o_tri.e2z = EdgeW'(i_vtx.pos_z) - EdgeW'(r_hpz[0]);
        o_tri.s1  = TedgeW'(r_htu[1]) - TedgeW'(r_htu[0]);
        o_tri.s2  = TedgeW'(i_vtx.tex_u) - TedgeW'(r_htu[0]);
        o_tri.t1  = TedgeW'(r_htv[1]) - TedgeW'(r_htv[0]);
        o_tri.t2  = TedgeW'(i_vtx.tex_v) - TedgeW'(r_htv[0]);
    end

endmodule

// ===== rtl/ttb_fifo.sv =====
// Two-entry triangle queue between the grouping front and the compute back.
module ttb_fifo import ttb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tri i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_tri o_data
);

    t_tri       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/ttb_norm.sv =====
// Sequential vector normalizer: range shift, sum of squares, square root, division.
module ttb_norm import ttb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_norm_req i_req,
    output t_norm_rsp o_rsp
);

    t_nstate          r_state, n_state;
    t_wide            c [3];
    logic [WideW-1:0] c_abs [3];
    logic [WideW-1:0] c_max;
    logic [WideW-1:0] r_m [3];
    logic [WideW-1:0] r_mx;
    logic             r_s [3];
    logic [1:0]       r_k;
    logic [SqW-1:0]   r_sq;
    logic [SumW-1:0]  r_sum;
    logic [SumW-1:0]  r_n;
    logic [SumW-1:0]  r_res;
    logic [SumW-1:0]  r_bit;
    logic [SumW-1:0]  trial;
    logic [SumW-1:0]  n_res;
    logic             sq_ge;
    logic [NumW-1:0]  r_rem;
    logic [NumW-1:0]  r_dv;
    logic [QW-1:0]    r_qacc;
    logic [QW-1:0]    q_n;
    logic             div_ge;
    logic [3:0]       r_dj;
    logic [1:0]       r_dk;
    t_unit            r_qo [3];
    logic             r_done;
    logic             r_zero;

    assign c[0] = i_req.cx;
    assign c[1] = i_req.cy;
    assign c[2] = i_req.cz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_abs[i] = c[i][WideW-1] ? WideW'(-c[i]) : WideW'(c[i]);
        end
        c_max = c_abs[0];
        if (c_abs[1] > c_max) begin
            c_max = c_abs[1];
        end
        if (c_abs[2] > c_max) begin
            c_max = c_abs[2];
        end
    end

    // One step of the digit-by-digit square root.
    assign trial = r_res + r_bit;
    assign sq_ge = (r_n >= trial);
    assign n_res = sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // One quotient bit of the rounded division.
    assign div_ge = (r_rem >= r_dv);
    assign q_n    = {r_qacc[QW-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            N_IDLE: begin
                if (i_req.start && (c_max != '0)) begin
                    n_state = N_SHIFT;
                end
            end
            N_SHIFT: begin
                if (!(|r_mx[WideW-1:MagW]) && r_mx[MagW-1]) begin
                    n_state = N_SQ;
                end
            end
            N_SQ: begin
                if (r_k == 2'd3) begin
                    n_state = N_SQRT;
                end
            end
            N_SQRT: begin
                if (r_bit[0]) begin
                    n_state = N_DIV;
                end
            end
            N_DIV: begin
                if ((r_dj == QLast) && (r_dk == 2'd2)) begin
                    n_state = N_IDLE;
                end
            end
            default: n_state = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ((r_state == N_IDLE) && i_req.start && (c_max == '0)) ||
                      ((r_state == N_DIV) && (r_dj == QLast) && (r_dk == 2'd2));
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_req.start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= c_abs[i];
                        r_s[i] <= c[i][WideW-1] ^ i_req.neg;
                    end
                    r_mx   <= c_max;
                    r_zero <= (c_max == '0);
                end
            end
            N_SHIFT: begin
                // Right shifts truncate; all three move by the same amount.
                if (|r_mx[WideW-1:MagW]) begin
                    r_mx <= r_mx >> 1;
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] >> 1;
                    end
                end else if (!r_mx[MagW-1]) begin
                    r_mx <= r_mx << 1;
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end
                r_k   <= 2'd0;
                r_sum <= '0;
            end
            N_SQ: begin
                if (r_k != 2'd3) begin
                    r_sq <= r_m[r_k][MagW-1:0] * r_m[r_k][MagW-1:0];
                end
                if (r_k != 2'd0) begin
                    r_sum <= r_sum + SumW'(r_sq);
                end
                r_k   <= r_k + 2'd1;
                r_n   <= r_sum + SumW'(r_sq);
                r_res <= '0;
                r_bit <= SqrtBit0;
            end
            N_SQRT: begin
                if (sq_ge) begin
                    r_n <= r_n - trial;
                end
                r_res  <= n_res;
                r_bit  <= r_bit >> 2;
                r_rem  <= {1'b0, r_m[0][MagW-1:0], {QW{1'b0}}} + NumW'(n_res[RootW-1:0]);
                r_dv   <= {n_res[RootW-1:0], {QW{1'b0}}};
                r_qacc <= '0;
                r_dj   <= 4'd0;
                r_dk   <= 2'd0;
            end
            N_DIV: begin
                if (r_dj == QLast) begin
                    r_qo[r_dk] <= r_s[r_dk] ? -UnitW'(q_n) : UnitW'(q_n);
                    if (r_dk != 2'd2) begin
                        r_rem <= {1'b0, r_m[r_dk + 2'd1][MagW-1:0], {QW{1'b0}}} +
                                 NumW'(r_res[RootW-1:0]);
                        r_dv  <= {r_res[RootW-1:0], {QW{1'b0}}};
                    end
                    r_qacc <= '0;
                    r_dj   <= 4'd0;
                    r_dk   <= r_dk + 2'd1;
                end else begin
                    r_rem  <= div_ge ? (r_rem - r_dv) : r_rem;
                    r_dv   <= r_dv >> 1;
                    r_qacc <= q_n;
                    r_dj   <= r_dj + 4'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = r_zero;
    assign o_rsp.qx   = r_qo[0];
    assign o_rsp.qy   = r_qo[1];
    assign o_rsp.qz   = r_qo[2];

endmodule

// ===== rtl/ttb_back.sv =====
// Triangle compute sequencer: products on one shared multiplier, normalizations, result beat.
module ttb_back import ttb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_tri      i_tri,
    output logic      o_pop,
    output t_norm_req o_req,
    input  t_norm_rsp i_rsp,
    ttb_bas_if.source o_bas
);

    t_bstate      r_state, n_state;
    t_tri         r_tri;
    logic [3:0]   r_step;
    logic         r_cross;
    logic         r_degen;
    t_prod        r_prod;
    t_wide        r_acc;
    t_wide        r_res [NumRes];
    t_unit        r_tq [3];
    t_unit        r_bq [3];
    t_unit        r_nq [3];
    logic         r_ov;
    t_unit        r_out [9];
    logic         r_out_degen;
    logic signed [EdgeW-1:0]  op_a;
    logic signed [TedgeW-1:0] op_b;
    t_prod        n_prod;
    t_wide        prod_ext;
    logic         last;
    logic         load_out;
    logic [2:0]   res_idx;
    logic         det_zero;

    assign n_prod   = op_a * op_b;
    assign prod_ext = {{(WideW-ProdW){r_prod[ProdW-1]}}, r_prod};
    assign last     = r_cross ? (r_step == CrossLast) : (r_step == GeoLast);
    assign res_idx  = r_cross ? (r_step[3:1] + 3'd1) : r_step[3:1];
    assign det_zero = (r_res[0] == '0);

    // Geometry pass: determinant, then t2*e1 - t1*e2, then s1*e2 - s2*e1.
    // Cross pass: tangent x binormal on the Q1.14 results.
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (!r_cross) begin
            case (r_step)
                4'd0:  begin op_a = EdgeW'(r_tri.s1); op_b = r_tri.t2; end
                4'd1:  begin op_a = EdgeW'(r_tri.s2); op_b = r_tri.t1; end
                4'd2:  begin op_a = r_tri.e1x; op_b = r_tri.t2; end
                4'd3:  begin op_a = r_tri.e2x; op_b = r_tri.t1; end
                4'd4:  begin op_a = r_tri.e1y; op_b = r_tri.t2; end
                4'd5:  begin op_a = r_tri.e2y; op_b = r_tri.t1; end
                4'd6:  begin op_a = r_tri.e1z; op_b = r_tri.t2; end
                4'd7:  begin op_a = r_tri.e2z; op_b = r_tri.t1; end
                4'd8:  begin op_a = r_tri.e2x; op_b = r_tri.s1; end
                4'd9:  begin op_a = r_tri.e1x; op_b = r_tri.s2; end
                4'd10: begin op_a = r_tri.e2y; op_b = r_tri.s1; end
                4'd11: begin op_a = r_tri.e1y; op_b = r_tri.s2; end
                4'd12: begin op_a = r_tri.e2z; op_b = r_tri.s1; end
                4'd13: begin op_a = r_tri.e1z; op_b = r_tri.s2; end
                default: ;
            endcase
        end else begin
            case (r_step)
                4'd0: begin op_a = EdgeW'(r_tq[1]); op_b = TedgeW'(r_bq[2]); end
                4'd1: begin op_a = EdgeW'(r_tq[2]); op_b = TedgeW'(r_bq[1]); end
                4'd2: begin op_a = EdgeW'(r_tq[2]); op_b = TedgeW'(r_bq[0]); end
                4'd3: begin op_a = EdgeW'(r_tq[0]); op_b = TedgeW'(r_bq[2]); end
                4'd4: begin op_a = EdgeW'(r_tq[0]); op_b = TedgeW'(r_bq[1]); end
                4'd5: begin op_a = EdgeW'(r_tq[1]); op_b = TedgeW'(r_bq[0]); end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        o_req.start = 1'b0;
        o_req.neg   = r_cross ? 1'b0 : r_res[0][WideW-1];
        o_req.cx    = r_res[1];
        o_req.cy    = r_res[2];
        o_req.cz    = r_res[3];
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_MUL;
                end
            end
            B_MUL: n_state = B_ACC;
            B_ACC: begin
                if (last) begin
                    n_state = B_CHK;
                end else begin
                    n_state = B_MUL;
                end
            end
            B_CHK: begin
                if (!r_cross && det_zero) begin
                    n_state = B_OUT;
                end else begin
                    o_req.start = 1'b1;
                    n_state     = r_cross ? B_NN : B_NT;
                end
            end
            B_NT: begin
                if (i_rsp.done) begin
                    if (i_rsp.zero) begin
                        n_state = B_OUT;
                    end else begin
                        o_req.start = 1'b1;
                        o_req.cx    = r_res[4];
                        o_req.cy    = r_res[5];
                        o_req.cz    = r_res[6];
                        n_state     = B_NB;
                    end
                end
            end
            B_NB: begin
                if (i_rsp.done) begin
                    n_state = i_rsp.zero ? B_OUT : B_MUL;
                end
            end
            B_NN: begin
                if (i_rsp.done) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (!r_ov || o_bas.ready) begin
                    load_out = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    r_tri   <= i_tri;
                    r_step  <= 4'd0;
                    r_cross <= 1'b0;
                    r_degen <= 1'b0;
                end
            end
            B_MUL: r_prod <= n_prod;
            B_ACC: begin
                if (!r_step[0]) begin
                    r_acc <= prod_ext;
                end else begin
                    r_res[res_idx] <= r_acc - prod_ext;
                end
                r_step <= last ? 4'd0 : r_step + 4'd1;
            end
            B_CHK: begin
                if (!r_cross && det_zero) begin
                    r_degen <= 1'b1;
                end
            end
            B_NT: begin
                if (i_rsp.done) begin
                    if (i_rsp.zero) begin
                        r_degen <= 1'b1;
                    end else begin
                        r_tq[0] <= i_rsp.qx;
                        r_tq[1] <= i_rsp.qy;
                        r_tq[2] <= i_rsp.qz;
                    end
                end
            end
            B_NB: begin
                if (i_rsp.done) begin
                    if (i_rsp.zero) begin
                        r_degen <= 1'b1;
                    end else begin
                        r_bq[0] <= i_rsp.qx;
                        r_bq[1] <= i_rsp.qy;
                        r_bq[2] <= i_rsp.qz;
                        r_cross <= 1'b1;
                        r_step  <= 4'd0;
                    end
                end
            end
            B_NN: begin
                if (i_rsp.done) begin
                    if (i_rsp.zero) begin
                        r_degen <= 1'b1;
                    end else begin
                        r_nq[0] <= i_rsp.qx;
                        r_nq[1] <= i_rsp.qy;
                        r_nq[2] <= i_rsp.qz;
                    end
                end
            end
            B_OUT: begin
                if (load_out) begin
                    for (int i = 0; i < 3; i++) begin
                        r_out[i]     <= r_degen ? '0 : r_tq[i];
                        r_out[3 + i] <= r_degen ? '0 : r_bq[i];
                        r_out[6 + i] <= r_degen ? '0 : r_nq[i];
                    end
                    r_out_degen <= r_degen;
                end
            end
            default: ;
        endcase
    end

    // The output register frees the sequencer while a beat waits downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (o_bas.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_bas.valid      = r_ov;
    assign o_bas.tangent_x  = r_out[0];
    assign o_bas.tangent_y  = r_out[1];
    assign o_bas.tangent_z  = r_out[2];
    assign o_bas.binormal_x = r_out[3];
    assign o_bas.binormal_y = r_out[4];
    assign o_bas.binormal_z = r_out[5];
    assign o_bas.normal_x   = r_out[6];
    assign o_bas.normal_y   = r_out[7];
    assign o_bas.normal_z   = r_out[8];
    assign o_bas.degenerate = r_out_degen;

endmodule

// ===== rtl/triangle_tangent_basis.sv =====
// Vertices come in one beat each and are grouped three at a time; the front takes a vertex in
// every cycle while its two-entry triangle queue has room. The back then works on one triangle
// at a time: 14 products on one shared 33x25 multiplier, each registered and then accumulated,
// normalizations of the tangent and the binormal, the cross product on the same multiplier, a
// normalization of the normal, and a load of the output register; each normalization runs a
// range shift, a sum of squares, a square root and three divisions. This sequential back sets
// the sustained rate. A zero determinant or vector ends the work early with a degenerate result.
module triangle_tangent_basis import ttb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ttb_vtx_if.sink   i_vtx,
    ttb_bas_if.source o_bas
);

    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    t_tri      tri_in;
    t_tri      tri_out;
    t_norm_req norm_req;
    t_norm_rsp norm_rsp;

    ttb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (i_vtx),
        .i_full  (full),
        .o_push  (push),
        .o_tri   (tri_in)
    );

    ttb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (tri_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (tri_out)
    );

    ttb_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (norm_req),
        .o_rsp   (norm_rsp)
    );

    ttb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_tri   (tri_out),
        .o_pop   (pop),
        .o_req   (norm_req),
        .i_rsp   (norm_rsp),
        .o_bas   (o_bas)
    );

endmodule

// ===== rtl/ttb_checker.sv =====
// Port-level checks of the triangle tangent basis block and their bind.
module ttb_checker import ttb_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_unit i_tx,
    input t_unit i_ty,
    input t_unit i_tz,
    input t_unit i_bx,
    input t_unit i_by,
    input t_unit i_bz,
    input t_unit i_nx,
    input t_unit i_ny,
    input t_unit i_nz,
    input logic  i_degen
);

    localparam t_unit One    = t_unit'(16384);
    localparam t_unit NegOne = t_unit'(-16384);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx) && $stable(i_nz) &&
        $stable(i_degen))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat valid right after reset");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degen |-> (i_tx == 0) && (i_ty == 0) && (i_tz == 0) &&
        (i_bx == 0) && (i_by == 0) && (i_bz == 0) && (i_nx == 0) && (i_ny == 0) &&
        (i_nz == 0))
        else $error("degenerate beat carries nonzero vectors");

    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_degen |-> (i_nx <= One) && (i_nx >= NegOne) &&
        (i_ny <= One) && (i_ny >= NegOne) && (i_nz <= One) && (i_nz >= NegOne) &&
        ((i_nx != 0) || (i_ny != 0) || (i_nz != 0)) &&
        ((i_tx != 0) || (i_ty != 0) || (i_tz != 0)))
        else $error("normalized vector out of range or zero");

endmodule

bind triangle_tangent_basis ttb_checker u_ttb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_bas.valid),
    .i_out_ready (o_bas.ready),
    .i_tx        (o_bas.tangent_x),
    .i_ty        (o_bas.tangent_y),
    .i_tz        (o_bas.tangent_z),
    .i_bx        (o_bas.binormal_x),
    .i_by        (o_bas.binormal_y),
    .i_bz        (o_bas.binormal_z),
    .i_nx        (o_bas.normal_x),
    .i_ny        (o_bas.normal_y),
    .i_nz        (o_bas.normal_z),
    .i_degen     (o_bas.degenerate)
);

// ===== bench/tb_top.sv =====
// Testbench for the triangle tangent basis block: queued vertex driver, basis checker.
module tb_top import ttb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic  mesh_start;
        t_pos  px, py, pz;
        t_tex  tu, tv;
    } t_vtx;

    typedef struct {
        t_unit tx, ty, tz, bx, by, bz, nx, ny, nz;
        logic  degen;
    } t_basis;

    localparam int CycleLimit = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ttb_vtx_if vtx ();
    ttb_bas_if bas ();

    triangle_tangent_basis dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx.sink),
        .o_bas  (bas.source)
    );

    always #5 i_clk = ~i_clk;

    t_vtx   pending_vtx[$];
    t_basis expected_basis[$];

    // Predictor state: first two vertices of the triangle being gathered.
    longint hold_px[2], hold_py[2], hold_pz[2], hold_tu[2], hold_tv[2];
    int     held_count;

    int errors = 0;
    int send_idle_pct = 34;
    int recv_idle_pct = 88;
    int hold_off = 0;
    bit pause_send = 0;
    longint cycles = 0;

    function automatic void queue_vertex(t_vtx v);
        pending_vtx = {pending_vtx, v};
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Scales a vector to unit length in Q1.14; returns 0 for a zero vector.
    function automatic bit unit_vector(input longint c[3], input bit neg, output longint q[3]);
        longint unsigned m[3];
        longint unsigned mx = 0, sum = 0, len, d;
        bit s[3];
        for (int i = 0; i < 3; i++) begin
            s[i] = (c[i] < 0) != neg;
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 24)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 23)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            d = (m[i] * 32768 + len) / (2 * len);
            if (d > 16384) d = 16384;
            q[i] = s[i] ? -longint'(d) : longint'(d);
        end
        return 1;
    endfunction

    task automatic predict_vertex(input t_vtx v);
        longint e1[3], e2[3], tg[3], bn[3], nm[3], tq[3], bq[3], nq[3];
        longint s1, s2, t1, t2, det;
        bit degen;
        t_basis r;
        if (v.mesh_start) held_count = 0;
        if (held_count < 2) begin
            hold_px[held_count] = v.px; hold_py[held_count] = v.py;
            hold_pz[held_count] = v.pz; hold_tu[held_count] = v.tu;
            hold_tv[held_count] = v.tv;
            held_count++;
            return;
        end
        held_count = 0;
        e1[0] = hold_px[1] - hold_px[0]; e1[1] = hold_py[1] - hold_py[0];
        e1[2] = hold_pz[1] - hold_pz[0];
        e2[0] = longint'(v.px) - hold_px[0]; e2[1] = longint'(v.py) - hold_py[0];
        e2[2] = longint'(v.pz) - hold_pz[0];
        s1 = hold_tu[1] - hold_tu[0]; s2 = longint'(v.tu) - hold_tu[0];
        t1 = hold_tv[1] - hold_tv[0]; t2 = longint'(v.tv) - hold_tv[0];
        det = s1 * t2 - s2 * t1;
        for (int i = 0; i < 3; i++) begin
            tg[i] = t2 * e1[i] - t1 * e2[i];
            bn[i] = s1 * e2[i] - s2 * e1[i];
        end
        degen = (det == 0);
        if (!degen) degen = !unit_vector(tg, det < 0, tq);
        if (!degen) degen = !unit_vector(bn, det < 0, bq);
        if (!degen) begin
            nm[0] = tq[1] * bq[2] - tq[2] * bq[1];
            nm[1] = tq[2] * bq[0] - tq[0] * bq[2];
            nm[2] = tq[0] * bq[1] - tq[1] * bq[0];
            degen = !unit_vector(nm, 1'b0, nq);
        end
        if (degen) begin
            r = '{default: '0};
            r.degen = 1'b1;
        end else begin
            r.tx = t_unit'(tq[0]); r.ty = t_unit'(tq[1]); r.tz = t_unit'(tq[2]);
            r.bx = t_unit'(bq[0]); r.by = t_unit'(bq[1]); r.bz = t_unit'(bq[2]);
            r.nx = t_unit'(nq[0]); r.ny = t_unit'(nq[1]); r.nz = t_unit'(nq[2]);
            r.degen = 1'b0;
        end
        expected_basis = {expected_basis, r};
    endtask

    // Driver: the current beat is predicted when it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vtx.valid <= 1'b0;
        end else begin
            if (vtx.valid && vtx.ready) begin
                predict_vertex(pending_vtx.pop_front());
            end
            if (vtx.valid && !vtx.ready) begin
                // Beat still waiting; hold it.
            end else if (pending_vtx.size() > 0 && !pause_send &&
                         $urandom_range(99) >= send_idle_pct) begin
                vtx.valid      <= 1'b1;
                vtx.mesh_start <= pending_vtx[0].mesh_start;
                vtx.pos_x      <= pending_vtx[0].px;
                vtx.pos_y      <= pending_vtx[0].py;
                vtx.pos_z      <= pending_vtx[0].pz;
                vtx.tex_u      <= pending_vtx[0].tu;
                vtx.tex_v      <= pending_vtx[0].tv;
            end else begin
                vtx.valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with a long hold-off when the test sets one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bas.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            bas.ready <= 1'b0;
        end else begin
            bas.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor and checker.
    always @(posedge i_clk) begin
        t_basis e;
        bit bad;
        if (i_rst_n && bas.valid && bas.ready) begin
            if (expected_basis.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected basis beat");
            end else begin
                e = expected_basis.pop_front();
                bad = e.tx != bas.tangent_x || e.ty != bas.tangent_y ||
                      e.tz != bas.tangent_z || e.bx != bas.binormal_x ||
                      e.by != bas.binormal_y || e.bz != bas.binormal_z ||
                      e.nx != bas.normal_x || e.ny != bas.normal_y ||
                      e.nz != bas.normal_z || e.degen != bas.degenerate;
                if (bad) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp t=%0d %0d %0d b=%0d %0d %0d n=%0d %0d %0d d=%0b got t=%0d %0d %0d b=%0d %0d %0d n=%0d %0d %0d d=%0b",
                            e.tx, e.ty, e.tz, e.bx, e.by, e.bz, e.nx, e.ny, e.nz, e.degen,
                            bas.tangent_x, bas.tangent_y, bas.tangent_z, bas.binormal_x,
                            bas.binormal_y, bas.binormal_z, bas.normal_x, bas.normal_y,
                            bas.normal_z, bas.degenerate);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_vtx rand_vertex(bit ms, int shift);
        t_vtx v;
        v.mesh_start = ms;
        v.px = t_pos'($signed($urandom()) >>> shift);
        v.py = t_pos'($signed($urandom()) >>> shift);
        v.pz = t_pos'($signed($urandom()) >>> shift);
        v.tu = t_tex'($urandom());
        v.tv = t_tex'($urandom());
        return v;
    endfunction

    function automatic t_vtx mk(bit ms, t_pos x, t_pos y, t_pos z, t_tex u, t_tex w);
        t_vtx v;
        v.mesh_start = ms; v.px = x; v.py = y; v.pz = z; v.tu = u; v.tv = w;
        return v;
    endfunction

    task automatic add_random_triangles(int n);
        int shift;
        for (int i = 0; i < n; i++) begin
            shift = $urandom_range(3) == 0 ? $urandom_range(24) : 0;
            if ($urandom_range(9) == 0) begin
                // Broken sequence: a partial triangle, dropped if the next vertex restarts the mesh.
                queue_vertex(rand_vertex(1'b1, shift));
                if ($urandom_range(1)) queue_vertex(rand_vertex(1'b0, shift));
            end
            queue_vertex(rand_vertex($urandom_range(1), shift));
            queue_vertex(rand_vertex(1'b0, shift));
            queue_vertex(rand_vertex(1'b0, shift));
        end
    endtask

    task automatic wait_drained();
        while (pending_vtx.size() > 0 || vtx.valid || expected_basis.size() > 0)
            @(posedge i_clk);
    endtask

    localparam t_pos PMax = 32'sh7fffffff;
    localparam t_pos PMin = 32'sh80000000;
    localparam t_tex TMax = 24'sh7fffff;
    localparam t_tex TMin = 24'sh800000;
    localparam t_tex One  = 24'sh010000;

    initial begin
        vtx.valid = 1'b0; vtx.mesh_start = 1'b0;
        vtx.pos_x = '0; vtx.pos_y = '0; vtx.pos_z = '0; vtx.tex_u = '0; vtx.tex_v = '0;
        bas.ready = 1'b0;
        held_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Unit triangle, then extremes.
        queue_vertex(mk(1, 0, 0, 0, 0, 0));
        queue_vertex(mk(0, 32'sh10000, 0, 0, One, 0));
        queue_vertex(mk(0, 0, 32'sh10000, 0, 0, One));
        queue_vertex(mk(0, PMin, PMin, PMin, TMin, TMin));
        queue_vertex(mk(0, PMax, PMax, PMax, TMax, TMin));
        queue_vertex(mk(0, PMin, PMax, PMin, TMin, TMax));
        // Negative determinant.
        queue_vertex(mk(0, 0, 0, 0, 0, 0));
        queue_vertex(mk(0, 32'sh10000, 0, 0, 0, One));
        queue_vertex(mk(0, 0, 32'sh10000, 0, One, 0));
        // Zero determinant.
        queue_vertex(mk(0, 5, 6, 7, One, One));
        queue_vertex(mk(0, 9, 1, 2, One, One));
        queue_vertex(mk(0, 3, 8, 4, One, One));
        // Zero vectors with nonzero determinant.
        queue_vertex(mk(0, 7, 7, 7, 0, 0));
        queue_vertex(mk(0, 7, 7, 7, One, 0));
        queue_vertex(mk(0, 7, 7, 7, 0, One));
        // Collinear edges: normal vanishes.
        queue_vertex(mk(0, 0, 0, 0, 0, 0));
        queue_vertex(mk(0, 32'sh10000, 0, 0, One, 0));
        queue_vertex(mk(0, 32'sh20000, 0, 0, 0, One));
        // Restart drops two held vertices, then a triangle.
        queue_vertex(mk(1, 1, 2, 3, 4, 5));
        queue_vertex(mk(0, -1, -2, -3, -4, -5));
        queue_vertex(mk(1, 0, 0, 0, 0, 0));
        queue_vertex(mk(0, 0, 0, 32'sh10000, One, 0));
        queue_vertex(mk(0, 32'sh10000, 0, 0, 0, One));
        wait_drained();

        add_random_triangles(55);
        // Long receiver hold-off while vertices keep coming.
        hold_off = 3000;
        wait_drained();

        send_idle_pct = 88; recv_idle_pct = 34;
        add_random_triangles(55);
        wait_drained();

        send_idle_pct = 0; recv_idle_pct = 0;
        add_random_triangles(55);
        // Sender pause until every result is in.
        while (pending_vtx.size() > 90) @(posedge i_clk);
        pause_send = 1;
        while (vtx.valid || expected_basis.size() > 0) @(posedge i_clk);
        pause_send = 0;
        wait_drained();

        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/ttb_pkg.sv
rtl/ttb_if.sv
rtl/ttb_front.sv
rtl/ttb_fifo.sv
rtl/ttb_norm.sv
rtl/ttb_back.sv
rtl/triangle_tangent_basis.sv
rtl/ttb_checker.sv
bench/tb_top.sv
